@@ rtl/core/fwa_pkg.sv @@
package fwa_pkg;

  // Q1.15 value of one.
  localparam logic [15:0] ONE_Q15 = 16'd32768;

  // Configuration port geometry.
  localparam int ADDR_W = 5;

  // Register reset values.
  localparam logic [15:0] BP_LOW_RST       = 16'd5238;
  localparam logic [15:0] BP_MID_RST       = 16'd7857;
  localparam logic [15:0] BP_HIGH_RST      = 16'd13184;
  localparam logic [15:0] LEVEL_DIM_RST    = 16'd0;
  localparam logic [15:0] LEVEL_NORMAL_RST = 16'd16384;
  localparam logic [15:0] LEVEL_BRIGHT_RST = 16'd32768;

  // Register indexes (word address).
  typedef enum logic [2:0] {
    REG_BP_LOW       = 3'd0,
    REG_BP_MID       = 3'd1,
    REG_BP_HIGH      = 3'd2,
    REG_LEVEL_DIM    = 3'd3,
    REG_LEVEL_NORMAL = 3'd4,
    REG_LEVEL_BRIGHT = 3'd5
  } reg_idx_t;

  // Where a sample lies against the breakpoints.
  typedef enum logic [1:0] {
    RGN_LOW  = 2'd0,
    RGN_RISE = 2'd1,
    RGN_FALL = 2'd2,
    RGN_HIGH = 2'd3
  } region_t;

  typedef struct packed {
    region_t     region;
    logic [15:0] delta;
    logic [15:0] span;
  } ramp_t;

  // Memberships: [0] low, [1] medium, [2] high.
  typedef logic [2:0][15:0] memb_t;

  // Place a sample against the breakpoints and pick the ramp to divide.
  function automatic ramp_t classify(input logic [15:0] x, input logic [15:0] lo,
                                     input logic [15:0] mid, input logic [15:0] hi);
    ramp_t r;
    if (x <= lo) begin
      r.region = RGN_LOW;
      r.delta  = 16'd0;
      r.span   = 16'd1;
    end else if (x <= mid) begin
      r.region = RGN_RISE;
      r.delta  = x - lo;
      r.span   = mid - lo;
    end else if (x <= hi) begin
      r.region = RGN_FALL;
      r.delta  = x - mid;
      r.span   = hi - mid;
    end else begin
      r.region = RGN_HIGH;
      r.delta  = 16'd0;
      r.span   = 16'd1;
    end
    return r;
  endfunction

  // The rising ramp is the quotient; the falling one is one minus it, less
  // one more unit when the division left a remainder.
  function automatic memb_t member(input region_t region, input logic [15:0] q,
                                   input logic nz);
    memb_t m;
    logic [16:0] t;
    t = {1'b0, ONE_Q15} - {1'b0, q} - {16'd0, nz};
    m = '0;
    case (region)
      RGN_LOW: begin
        m[0] = ONE_Q15;
      end
      RGN_RISE: begin
        m[0] = t[15:0];
        m[1] = q;
      end
      RGN_FALL: begin
        m[1] = t[15:0];
        m[2] = q;
      end
      default: begin
        m[2] = ONE_Q15;
      end
    endcase
    return m;
  endfunction

endpackage

@@ rtl/core/fwa_div.sv @@
module fwa_div #(
  parameter int DW = 16,
  parameter int QW = 16,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [DW-1:0] rem_init,
  input  logic [QW-1:0] num_lo,
  input  logic [DW-1:0] divisor,
  input  logic [SW-1:0] side_in,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [QW-1:0] quot,
  output logic          rem_nz,
  output logic [SW-1:0] side_out
);

  // Two quotient bits per stage.
  localparam int STG = QW / 2;

  logic [STG-1:0] v;
  logic [STG-1:0] ld;
  logic [DW-1:0]  r    [STG];
  logic [QW-1:0]  lo   [STG];
  logic [QW-1:0]  q    [STG];
  logic [DW-1:0]  d    [STG];
  logic [SW-1:0]  s    [STG];

  // One restoring step: shift in a bit, subtract when it fits.
  function automatic logic [DW:0] div_step(input logic [DW-1:0] rr, input logic b,
                                           input logic [DW-1:0] dd);
    logic [DW:0] t;
    logic [DW:0] diff;
    t    = {rr, b};
    diff = t - {1'b0, dd};
    if (t >= {1'b0, dd}) begin
      div_step = {1'b1, diff[DW-1:0]};
    end else begin
      div_step = {1'b0, t[DW-1:0]};
    end
  endfunction

  // A stage loads when it is empty or its content moves on.
  always_comb begin
    ld[STG-1] = !v[STG-1] || out_ready;
    for (int k = STG - 2; k >= 0; k--) begin
      ld[k] = !v[k] || ld[k+1];
    end
  end

  assign in_ready = ld[0];

  for (genvar k = 0; k < STG; k++) begin : g_stage
    logic          src_v;
    logic [DW-1:0] src_r;
    logic [QW-1:0] src_lo;
    logic [QW-1:0] src_q;
    logic [DW-1:0] src_d;
    logic [SW-1:0] src_s;
    logic [DW:0]   st1;
    logic [DW:0]   st2;

    if (k == 0) begin : g_first
      assign src_v  = in_valid;
      assign src_r  = rem_init;
      assign src_lo = num_lo;
      assign src_q  = '0;
      assign src_d  = divisor;
      assign src_s  = side_in;
    end else begin : g_next
      assign src_v  = v[k-1];
      assign src_r  = r[k-1];
      assign src_lo = lo[k-1];
      assign src_q  = q[k-1];
      assign src_d  = d[k-1];
      assign src_s  = s[k-1];
    end

    always_comb begin
      st1 = div_step(src_r, src_lo[QW-1], src_d);
      st2 = div_step(st1[DW-1:0], src_lo[QW-2], src_d);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (ld[k]) begin
        v[k] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (ld[k]) begin
        r[k]  <= st2[DW-1:0];
        q[k]  <= {src_q[QW-3:0], st1[DW], st2[DW]};
        lo[k] <= {src_lo[QW-3:0], 2'b00};
        d[k]  <= src_d;
        s[k]  <= src_s;
      end
    end
  end

  assign out_valid = v[STG-1];
  assign quot      = q[STG-1];
  assign rem_nz    = |r[STG-1];
  assign side_out  = s[STG-1];

endmodule

@@ rtl/core/two_input_fuzzy_weighted_average_unit.sv @@
// Two-input fuzzy weighted average unit.
// A pair of unsigned Q8.8 samples enters on the input channel (in_valid,
// in_ready, sample_one, sample_two); one Q1.15 drive_level per pair leaves
// on the output channel (out_valid, out_ready), in input order.
// Each sample gets low, medium and high memberships from the three
// breakpoints; nine rule strengths are pairwise minimums, and the result is
// the strength-weighted average of the dim, normal and bright levels.
// From a transfer in to the result on the output register, the pipeline has
// one classify stage, two 8-stage ramp dividers, a min/multiply
// stage, two adder stages and an 8-stage final divider, two quotient bits
// per divider stage. One pair is taken every cycle while in_ready is high.
// Each stage holds its item when the next one is full and stalled, so a
// stalled receiver fills the empty stages before in_ready drops; nothing is
// lost or repeated.
// Reset empties the pipeline and loads the default breakpoints and levels.
// Registers sit on the APB port at byte addresses 0 to 20; write them only
// while the pipeline is empty.
module two_input_fuzzy_weighted_average_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fwa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [15:0]                sample_one,
  input  logic [15:0]                sample_two,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [15:0]                drive_level
);

  logic [15:0] bp_low, bp_mid, bp_high;
  logic [15:0] level_dim, level_normal, level_bright;
  fwa_pkg::reg_idx_t widx;

  // Configuration registers.
  assign pready = 1'b1;
  assign widx   = fwa_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      bp_low       <= fwa_pkg::BP_LOW_RST;
      bp_mid       <= fwa_pkg::BP_MID_RST;
      bp_high      <= fwa_pkg::BP_HIGH_RST;
      level_dim    <= fwa_pkg::LEVEL_DIM_RST;
      level_normal <= fwa_pkg::LEVEL_NORMAL_RST;
      level_bright <= fwa_pkg::LEVEL_BRIGHT_RST;
    end else if (psel && penable && pwrite) begin
      case (widx)
        fwa_pkg::REG_BP_LOW:       bp_low       <= pwdata[15:0];
        fwa_pkg::REG_BP_MID:       bp_mid       <= pwdata[15:0];
        fwa_pkg::REG_BP_HIGH:      bp_high      <= pwdata[15:0];
        fwa_pkg::REG_LEVEL_DIM:    level_dim    <= pwdata[15:0];
        fwa_pkg::REG_LEVEL_NORMAL: level_normal <= pwdata[15:0];
        fwa_pkg::REG_LEVEL_BRIGHT: level_bright <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (widx)
      fwa_pkg::REG_BP_LOW:       prdata = {16'd0, bp_low};
      fwa_pkg::REG_BP_MID:       prdata = {16'd0, bp_mid};
      fwa_pkg::REG_BP_HIGH:      prdata = {16'd0, bp_high};
      fwa_pkg::REG_LEVEL_DIM:    prdata = {16'd0, level_dim};
      fwa_pkg::REG_LEVEL_NORMAL: prdata = {16'd0, level_normal};
      fwa_pkg::REG_LEVEL_BRIGHT: prdata = {16'd0, level_bright};
      default:                   prdata = 32'd0;
    endcase
  end

  // Handshake chain between stages.
  logic a_v, a_ld;
  logic m_v, m_ld;
  logic n_v, n_ld;
  logic p_v, p_ld;
  logic d1_in_ready, d1_out_valid, d2_in_ready, d2_out_valid, d3_in_ready;

  assign a_ld     = !a_v || d1_in_ready;
  assign m_ld     = !m_v || n_ld;
  assign n_ld     = !n_v || p_ld;
  assign p_ld     = !p_v || d3_in_ready;
  assign in_ready = a_ld;

  // Classify stage: region and ramp operands of both samples.
  fwa_pkg::ramp_t a_r1, a_r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (a_ld) begin
      a_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ld) begin
      a_r1 <= fwa_pkg::classify(sample_one, bp_low, bp_mid, bp_high);
      a_r2 <= fwa_pkg::classify(sample_two, bp_low, bp_mid, bp_high);
    end
  end

  // Ramp of the first sample: delta * 32768 / span.
  localparam int SIDE1_W = $bits(fwa_pkg::ramp_t) + 2;
  logic [15:0]        d1_q;
  logic               d1_nz;
  logic [SIDE1_W-1:0] d1_side;
  fwa_pkg::ramp_t     d1_r2;
  fwa_pkg::region_t   d1_rg1;
  fwa_pkg::memb_t     m1_c;

  fwa_div #(.DW(16), .QW(16), .SW(SIDE1_W)) u_div_one (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_v),
    .in_ready  (d1_in_ready),
    .rem_init  ({1'b0, a_r1.delta[15:1]}),
    .num_lo    ({a_r1.delta[0], 15'd0}),
    .divisor   (a_r1.span),
    .side_in   ({a_r2, a_r1.region}),
    .out_valid (d1_out_valid),
    .out_ready (d2_in_ready),
    .quot      (d1_q),
    .rem_nz    (d1_nz),
    .side_out  (d1_side)
  );

  assign d1_r2  = fwa_pkg::ramp_t'(d1_side[SIDE1_W-1:2]);
  assign d1_rg1 = fwa_pkg::region_t'(d1_side[1:0]);
  assign m1_c   = fwa_pkg::member(d1_rg1, d1_q, d1_nz);

  // Ramp of the second sample, carrying the first memberships along.
  localparam int SIDE2_W = $bits(fwa_pkg::memb_t) + 2;
  logic [15:0]        d2_q;
  logic               d2_nz;
  logic [SIDE2_W-1:0] d2_side;
  fwa_pkg::memb_t     m1_d, m2_c;

  fwa_div #(.DW(16), .QW(16), .SW(SIDE2_W)) u_div_two (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (d1_out_valid),
    .in_ready  (d2_in_ready),
    .rem_init  ({1'b0, d1_r2.delta[15:1]}),
    .num_lo    ({d1_r2.delta[0], 15'd0}),
    .divisor   (d1_r2.span),
    .side_in   ({m1_c, d1_r2.region}),
    .out_valid (d2_out_valid),
    .out_ready (m_ld),
    .quot      (d2_q),
    .rem_nz    (d2_nz),
    .side_out  (d2_side)
  );

  assign m1_d = fwa_pkg::memb_t'(d2_side[SIDE2_W-1:2]);
  assign m2_c = fwa_pkg::member(fwa_pkg::region_t'(d2_side[1:0]), d2_q, d2_nz);

  // Rule stage: strengths and weighted levels.
  logic [15:0] str  [9];
  logic [31:0] prod [9];
  logic [15:0] lv   [3];

  assign lv[0] = level_dim;
  assign lv[1] = level_normal;
  assign lv[2] = level_bright;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (m_ld) begin
      m_v <= d2_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ld) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (m1_d[i] < m2_c[j]) begin
            str[3*i+j]  <= m1_d[i];
            prod[3*i+j] <= m1_d[i] * lv[j];
          end else begin
            str[3*i+j]  <= m2_c[j];
            prod[3*i+j] <= m2_c[j] * lv[j];
          end
        end
      end
    end
  end

  // Row sums of three rules each.
  logic [33:0] n_num [3];
  logic [17:0] n_den [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      n_v <= 1'b0;
    end else if (n_ld) begin
      n_v <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (n_ld) begin
      for (int i = 0; i < 3; i++) begin
        n_num[i] <= {2'b00, prod[3*i]} + {2'b00, prod[3*i+1]} + {2'b00, prod[3*i+2]};
        n_den[i] <= {2'b00, str[3*i]} + {2'b00, str[3*i+1]} + {2'b00, str[3*i+2]};
      end
    end
  end

  // Totals for the final division.
  logic [34:0] p_num;
  logic [18:0] p_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_v <= 1'b0;
    end else if (p_ld) begin
      p_v <= n_v;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ld) begin
      p_num <= {1'b0, n_num[0]} + {1'b0, n_num[1]} + {1'b0, n_num[2]};
      p_den <= {1'b0, n_den[0]} + {1'b0, n_den[1]} + {1'b0, n_den[2]};
    end
  end

  // Weighted average: the quotient never exceeds the largest level.
  logic [15:0] d3_q;
  logic        d3_nz;
  logic        d3_zero;

  fwa_div #(.DW(19), .QW(16), .SW(1)) u_div_avg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p_v),
    .in_ready  (d3_in_ready),
    .rem_init  (p_num[34:16]),
    .num_lo    (p_num[15:0]),
    .divisor   (p_den),
    .side_in   (p_den == 19'd0),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .quot      (d3_q),
    .rem_nz    (d3_nz),
    .side_out  (d3_zero)
  );

  // A zero strength sum gives zero; the remainder is not needed here.
  assign drive_level = (d3_zero || (d3_nz && 1'b0)) ? 16'd0 : d3_q;

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int Q15_ONE = 32768;

  // Scoreboard: predicts the drive level of each sample pair and checks results.
  class drive_level_scoreboard;
    int unsigned bp_low, bp_mid, bp_high;
    int unsigned lvl[3];
    logic [15:0] pending_levels[$];
    int errors;

    function new();
      bp_low = fwa_pkg::BP_LOW_RST;
      bp_mid = fwa_pkg::BP_MID_RST;
      bp_high = fwa_pkg::BP_HIGH_RST;
      lvl[0] = fwa_pkg::LEVEL_DIM_RST;
      lvl[1] = fwa_pkg::LEVEL_NORMAL_RST;
      lvl[2] = fwa_pkg::LEVEL_BRIGHT_RST;
      errors = 0;
    endfunction

    function void set_reg(fwa_pkg::reg_idx_t idx, logic [15:0] v);
      case (idx)
        fwa_pkg::REG_BP_LOW: bp_low = v;
        fwa_pkg::REG_BP_MID: bp_mid = v;
        fwa_pkg::REG_BP_HIGH: bp_high = v;
        fwa_pkg::REG_LEVEL_DIM: lvl[0] = v;
        fwa_pkg::REG_LEVEL_NORMAL: lvl[1] = v;
        default: lvl[2] = v;
      endcase
    endfunction

    function int unsigned slope(int unsigned delta, int unsigned span);
      if (span == 0) return Q15_ONE;
      return (delta * Q15_ONE) / span;
    endfunction

    // Low, medium and high memberships of one sample, each ramp rounded down.
    function void grade(int unsigned x, output int unsigned m[3]);
      m = '{0, 0, 0};
      if (x <= bp_low) begin
        m[0] = Q15_ONE;
      end else if (x <= bp_mid) begin
        m[0] = slope(bp_mid - x, bp_mid - bp_low);
        m[1] = slope(x - bp_low, bp_mid - bp_low);
      end else if (x <= bp_high) begin
        m[1] = slope(bp_high - x, bp_high - bp_mid);
        m[2] = slope(x - bp_mid, bp_high - bp_mid);
      end else begin
        m[2] = Q15_ONE;
      end
    endfunction

    function void note_pair(logic [15:0] s1, logic [15:0] s2);
      int unsigned m1[3], m2[3], s;
      longint unsigned num, den;
      num = 0;
      den = 0;
      grade(s1, m1);
      grade(s2, m2);
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          s = (m1[i] < m2[j]) ? m1[i] : m2[j];
          num += longint'(s) * lvl[j];
          den += s;
        end
      end
      pending_levels.push_back(den == 0 ? 16'd0 : 16'(num / den));
    endfunction

    function void check_level(logic [15:0] got);
      logic [15:0] want;
      if (pending_levels.size() == 0) begin
        $error("drive_level: unexpected result %0d", got);
        errors++;
        return;
      end
      want = pending_levels.pop_front();
      if (got !== want) begin
        $error("drive_level: expected %0d, actual %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [fwa_pkg::ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [15:0] sample_one, sample_two, drive_level;

  drive_level_scoreboard board = new();
  int send_idle_pct = 0, recv_stall_pct = 0;
  int hold_off_cycles = 0;
  bit done = 0;

  two_input_fuzzy_weighted_average_unit dut (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Track input transfers and check output transfers.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) board.note_pair(sample_one, sample_two);
    if (!rst && out_valid && out_ready) board.check_level(drive_level);
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ready <= 0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic reg_write(fwa_pkg::reg_idx_t idx, logic [15:0] v);
    @(posedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= fwa_pkg::ADDR_W'(4 * idx);
    pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    board.set_reg(idx, v);
  endtask

  // Offer one pair; valid stays up across back-to-back transfers.
  task automatic send_pair(logic [15:0] s1, logic [15:0] s2);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    sample_one <= s1;
    sample_two <= s2;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending_levels.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [15:0] near_break();
    int unsigned b;
    case ($urandom_range(2))
      0: b = board.bp_low;
      1: b = board.bp_mid;
      default: b = board.bp_high;
    endcase
    return 16'(b + $urandom_range(4) - 2);
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return near_break();
      default: return 16'($urandom_range(board.bp_high + 400,
                                         board.bp_low > 400 ? board.bp_low - 400 : 0));
    endcase
  endfunction

  task automatic random_phase(int count, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (count) send_pair(pick_sample(), pick_sample());
    drain();
  endtask

  task automatic set_all(logic [15:0] lo, logic [15:0] mid, logic [15:0] hi,
                         logic [15:0] d, logic [15:0] n, logic [15:0] b);
    reg_write(fwa_pkg::REG_BP_LOW, lo);
    reg_write(fwa_pkg::REG_BP_MID, mid);
    reg_write(fwa_pkg::REG_BP_HIGH, hi);
    reg_write(fwa_pkg::REG_LEVEL_DIM, d);
    reg_write(fwa_pkg::REG_LEVEL_NORMAL, n);
    reg_write(fwa_pkg::REG_LEVEL_BRIGHT, b);
  endtask

  initial begin
    rst = 1;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    in_valid = 0;
    sample_one = 0;
    sample_two = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: field extremes and samples on each breakpoint.
    send_pair(16'd0, 16'd0);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'd0, 16'hFFFF);
    send_pair(16'hFFFF, 16'd0);
    send_pair(fwa_pkg::BP_LOW_RST, fwa_pkg::BP_MID_RST);
    send_pair(fwa_pkg::BP_MID_RST, fwa_pkg::BP_HIGH_RST);
    send_pair(fwa_pkg::BP_HIGH_RST, fwa_pkg::BP_LOW_RST);
    send_pair(fwa_pkg::BP_LOW_RST + 16'd1, fwa_pkg::BP_MID_RST + 16'd1);
    send_pair(fwa_pkg::BP_HIGH_RST + 16'd1, fwa_pkg::BP_HIGH_RST - 16'd1);
    send_pair(16'h5555, 16'hAAAA);
    send_pair(16'd6000, 16'd10000);
    drain();

    // Unordered breakpoints and levels above one.
    set_all(16'd9000, 16'd3000, 16'd6000, 16'hFFFF, 16'd0, 16'd40000);
    send_pair(16'd2000, 16'd4000);
    send_pair(16'd7000, 16'd9500);
    send_pair(16'd3000, 16'd6000);
    drain();
    // Equal breakpoints at the top of the range.
    set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd32768, 16'd0);
    send_pair(16'hFFFE, 16'hFFFF);
    send_pair(16'd0, 16'h8000);
    drain();

    // Random phases across idling patterns and settings.
    set_all(fwa_pkg::BP_LOW_RST, fwa_pkg::BP_MID_RST, fwa_pkg::BP_HIGH_RST,
            16'd1000, 16'd20000, 16'd32768);
    random_phase(300, 0, 0);
    random_phase(250, 75, 0);
    set_all(16'd0, 16'd1, 16'd2, 16'd32768, 16'd0, 16'd32768);
    random_phase(150, 0, 75);
    set_all(16'd100, 16'd30000, 16'hFFFE, 16'd0, 16'd32768, 16'd12345);
    random_phase(250, 0, 75);
    set_all(16'd1200, 16'd1300, 16'd60000, 16'd500, 16'd32768, 16'd7000);
    random_phase(300, 30, 30);

    // Long receiver hold-off while the sender keeps offering.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 200;
    repeat (120) send_pair(pick_sample(), pick_sample());
    drain();
    random_phase(200, 0, 0);
    done = 1;
  end

  initial begin
    wait (done);
    if (board.errors == 0 && board.pending_levels.size() == 0) begin
      $display("two_input_fuzzy_weighted_average_unit verification clean");
    end else begin
      $display("two_input_fuzzy_weighted_average_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("two_input_fuzzy_weighted_average_unit verification failed");
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/fwa_pkg.sv
rtl/core/fwa_div.sv
rtl/core/two_input_fuzzy_weighted_average_unit.sv
test/tb.sv
